/* design/stba_pkg.sv */
`default_nettype none
package stba_pkg;

  localparam int DEF_TABLE_DEPTH = 2048;
  localparam int POS_W  = 13;
  localparam int ENT_W  = 13;
  localparam int TOT_W  = 12;
  localparam int ADDR_W = 15;

  localparam logic [1:0] REQ_FIXED  = 2'd0;
  localparam logic [1:0] REQ_SEARCH = 2'd1;
  localparam logic [1:0] REQ_FREE   = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NO_ROOM = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [10:0] start_block;
    logic [11:0] block_count;
    logic [11:0] search_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] placed_block;
    logic [11:0] next_candidate;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ENT_W-1:0]  wr_data;
  } mem_req_t;

  function automatic logic [POS_W-1:0] seg_len(input logic [ENT_W-1:0] v);
    logic [ENT_W-1:0] neg;
    neg = -v;
    return v[ENT_W-1] ? POS_W'(neg) : POS_W'(v);
  endfunction

endpackage
`default_nettype wire

/* design/stba_table.sv */
`default_nettype none
module stba_table
  import stba_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  wire logic             clk,
  input  wire mem_req_t         mreq,
  output logic [ENT_W-1:0]      rd_data
);
  localparam int AW = $clog2(TABLE_DEPTH);

  logic [ENT_W-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (mreq.wr_en) begin
      mem[AW'(mreq.wr_addr)] <= mreq.wr_data;
    end
    rd_data <= mem[AW'(mreq.rd_addr)];
  end
endmodule
`default_nettype wire

/* design/stba_ctrl.sv */
`default_nettype none
module stba_ctrl
  import stba_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire in_item_t         in_item,
  output logic                  busy,
  output logic                  out_valid,
  output out_item_t             out_item,
  input  wire logic             cfg_valid,
  input  wire logic [TOT_W-1:0] cfg_data,
  output mem_req_t              mreq,
  input  wire logic [ENT_W-1:0] rd_data
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int TOT_RST = (TABLE_DEPTH < 2048) ? TABLE_DEPTH : 2048;
  localparam int TOT_MAX = (TABLE_DEPTH < 4095) ? TABLE_DEPTH : 4095;

  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_FX_RD  = 5'd2;
  localparam logic [4:0] S_FX_CK  = 5'd3;
  localparam logic [4:0] S_FX_W2  = 5'd4;
  localparam logic [4:0] S_WK_RD  = 5'd5;
  localparam logic [4:0] S_WK_CK  = 5'd6;
  localparam logic [4:0] S_FX_DEC = 5'd7;
  localparam logic [4:0] S_FW1    = 5'd8;
  localparam logic [4:0] S_FW2    = 5'd9;
  localparam logic [4:0] S_FW3    = 5'd10;
  localparam logic [4:0] S_FAIL   = 5'd11;
  localparam logic [4:0] S_FR_DEC = 5'd12;
  localparam logic [4:0] S_FR_CK  = 5'd13;
  localparam logic [4:0] S_FR_W2  = 5'd14;
  localparam logic [4:0] S_FR_NRD = 5'd15;
  localparam logic [4:0] S_FR_NCK = 5'd16;
  localparam logic [4:0] S_FR_NW2 = 5'd17;

  logic [4:0]       state_r, state_nxt;
  logic [1:0]       typ_r, typ_nxt;
  logic [POS_W-1:0] s_r, s_nxt, n_r, n_nxt, e_r, e_nxt, c_r, c_nxt;
  logic [POS_W-1:0] wc_r, wc_nxt, wp_r, wp_nxt, nc_r, nc_nxt;
  logic [POS_W-1:0] idx_r, idx_nxt, ilen_r, ilen_nxt;
  logic [ENT_W-1:0] wpv_r, wpv_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;
  logic [TOT_W-1:0] total_r, total_nxt;
  logic             ov_r;
  out_item_t        oi_r;

  logic             fin;
  out_item_t        fin_item;
  logic [POS_W-1:0] tot, in_s, in_n, in_e, len, nxt_pos;
  logic [ENT_W-1:0] cfg_clip;
  logic             vpos;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_item  = oi_r;

  always_comb begin
    tot      = POS_W'(total_r);
    in_s     = POS_W'(in_item.start_block);
    in_n     = POS_W'(in_item.block_count);
    in_e     = POS_W'(in_item.search_end);
    if (in_e > tot) begin
      in_e = tot;
    end
    len      = seg_len(rd_data);
    vpos     = !rd_data[ENT_W-1] && (rd_data != '0);
    nxt_pos  = idx_r + ilen_r;
    cfg_clip = ENT_W'(cfg_data);
    if (cfg_data == '0) begin
      cfg_clip = ENT_W'(1);
    end else if (32'(cfg_data) > TOT_MAX) begin
      cfg_clip = ENT_W'(TOT_MAX);
    end

    state_nxt = state_r;
    typ_nxt   = typ_r;
    s_nxt     = s_r;
    n_nxt     = n_r;
    e_nxt     = e_r;
    c_nxt     = c_r;
    wc_nxt    = wc_r;
    wp_nxt    = wp_r;
    wpv_nxt   = wpv_r;
    nc_nxt    = nc_r;
    idx_nxt   = idx_r;
    ilen_nxt  = ilen_r;
    clr_nxt   = clr_r;
    total_nxt = total_r;
    fin       = 1'b0;
    fin_item  = '0;
    mreq      = '0;

    case (state_r)
      S_CLR: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_addr = ADDR_W'(clr_r);
        mreq.wr_data = (clr_r == '0) ? ENT_W'(total_r) : '0;
        clr_nxt      = clr_r + AW'(1);
        if (clr_r == AW'(TABLE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          typ_nxt = in_item.req_type;
          s_nxt   = in_s;
          c_nxt   = in_s;
          n_nxt   = in_n;
          e_nxt   = in_e;
          wc_nxt  = '0;
          wp_nxt  = '0;
          wpv_nxt = '0;
          if (in_item.req_type > REQ_FREE || in_s >= tot) begin
            fin = 1'b1;
            fin_item.status = ST_BAD;
          end else if (in_item.req_type == REQ_FREE) begin
            state_nxt = S_WK_RD;
          end else if (in_n == '0) begin
            fin = 1'b1;
            fin_item.status = ST_BAD;
          end else if (in_item.req_type == REQ_FIXED) begin
            if (in_s + in_n > tot) begin
              fin = 1'b1;
              fin_item.status = ST_BAD;
            end else begin
              state_nxt = S_FX_RD;
            end
          end else if (in_s + in_n > in_e) begin
            fin = 1'b1;
            fin_item.status = ST_NO_ROOM;
          end else begin
            state_nxt = S_FX_RD;
          end
        end
      end
      S_FX_RD: begin
        mreq.rd_addr = ADDR_W'(c_r);
        state_nxt    = S_FX_CK;
      end
      S_FX_CK: begin
        if (rd_data != '0) begin
          if (vpos && len > n_r) begin
            mreq.wr_en   = 1'b1;
            mreq.wr_addr = ADDR_W'(c_r + n_r);
            mreq.wr_data = ENT_W'(len - n_r);
            state_nxt    = S_FX_W2;
          end else if (vpos && len == n_r) begin
            mreq.wr_en   = 1'b1;
            mreq.wr_addr = ADDR_W'(c_r);
            mreq.wr_data = ENT_W'(-n_r);
            fin          = 1'b1;
            fin_item.placed_block = c_r[10:0];
            state_nxt    = S_IDLE;
          end else begin
            nc_nxt    = c_r + len;
            state_nxt = S_FAIL;
          end
        end else begin
          wc_nxt    = '0;
          wp_nxt    = '0;
          wpv_nxt   = '0;
          state_nxt = S_WK_RD;
        end
      end
      S_FX_W2: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_addr = ADDR_W'(c_r);
        mreq.wr_data = ENT_W'(-n_r);
        fin          = 1'b1;
        fin_item.placed_block = c_r[10:0];
        state_nxt    = S_IDLE;
      end
      S_WK_RD: begin
        mreq.rd_addr = ADDR_W'(wc_r);
        if (wc_r < c_r && wc_r < tot) begin
          state_nxt = S_WK_CK;
        end else begin
          state_nxt = (typ_r == REQ_FREE) ? S_FR_DEC : S_FX_DEC;
        end
      end
      S_WK_CK: begin
        if (len == '0) begin
          state_nxt = (typ_r == REQ_FREE) ? S_FR_DEC : S_FX_DEC;
        end else begin
          wp_nxt    = wc_r;
          wpv_nxt   = rd_data;
          wc_nxt    = wc_r + len;
          state_nxt = S_WK_RD;
        end
      end
      S_FX_DEC: begin
        if (!wpv_r[ENT_W-1] && wpv_r != '0 && wc_r >= c_r && wc_r - c_r >= n_r) begin
          state_nxt = S_FW1;
        end else begin
          nc_nxt    = wc_r;
          state_nxt = S_FAIL;
        end
      end
      S_FW1: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_addr = ADDR_W'(c_r);
        mreq.wr_data = ENT_W'(-n_r);
        state_nxt    = S_FW2;
      end
      S_FW2: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_addr = ADDR_W'(wp_r);
        mreq.wr_data = ENT_W'(c_r - wp_r);
        if (wc_r > c_r + n_r) begin
          state_nxt = S_FW3;
        end else begin
          fin       = 1'b1;
          fin_item.placed_block = c_r[10:0];
          state_nxt = S_IDLE;
        end
      end
      S_FW3: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_addr = ADDR_W'(c_r + n_r);
        mreq.wr_data = ENT_W'(wc_r - c_r - n_r);
        fin          = 1'b1;
        fin_item.placed_block = c_r[10:0];
        state_nxt    = S_IDLE;
      end
      S_FAIL: begin
        if (typ_r == REQ_FIXED) begin
          fin       = 1'b1;
          fin_item.status = ST_NO_ROOM;
          fin_item.next_candidate = nc_r[11:0];
          state_nxt = S_IDLE;
        end else if (nc_r > c_r && nc_r + n_r <= e_r) begin
          c_nxt     = nc_r;
          state_nxt = S_FX_RD;
        end else begin
          fin       = 1'b1;
          fin_item.status = ST_NO_ROOM;
          state_nxt = S_IDLE;
        end
      end
      S_FR_DEC: begin
        mreq.rd_addr = ADDR_W'(s_r);
        if (wc_r != s_r) begin
          fin       = 1'b1;
          fin_item.status = ST_IGNORED;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_FR_CK;
        end
      end
      S_FR_CK: begin
        if (!rd_data[ENT_W-1]) begin
          fin       = 1'b1;
          fin_item.status = ST_IGNORED;
          state_nxt = S_IDLE;
        end else if (wp_r != s_r && !wpv_r[ENT_W-1] && wpv_r != '0) begin
          mreq.wr_en   = 1'b1;
          mreq.wr_addr = ADDR_W'(wp_r);
          mreq.wr_data = ENT_W'(seg_len(wpv_r) + len);
          idx_nxt      = wp_r;
          ilen_nxt     = seg_len(wpv_r) + len;
          state_nxt    = S_FR_W2;
        end else begin
          mreq.wr_en   = 1'b1;
          mreq.wr_addr = ADDR_W'(s_r);
          mreq.wr_data = ENT_W'(len);
          idx_nxt      = s_r;
          ilen_nxt     = len;
          state_nxt    = S_FR_NRD;
        end
      end
      S_FR_W2: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_addr = ADDR_W'(s_r);
        mreq.wr_data = '0;
        state_nxt    = S_FR_NRD;
      end
      S_FR_NRD: begin
        mreq.rd_addr = ADDR_W'(nxt_pos);
        if (nxt_pos < tot) begin
          state_nxt = S_FR_NCK;
        end else begin
          fin       = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_FR_NCK: begin
        if (vpos) begin
          mreq.wr_en   = 1'b1;
          mreq.wr_addr = ADDR_W'(idx_r);
          mreq.wr_data = ENT_W'(ilen_r + len);
          state_nxt    = S_FR_NW2;
        end else begin
          fin       = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_FR_NW2: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_addr = ADDR_W'(nxt_pos);
        mreq.wr_data = '0;
        fin          = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_valid) begin
      total_nxt = cfg_clip[TOT_W-1:0];
      clr_nxt   = '0;
      state_nxt = S_CLR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      total_r <= TOT_W'(TOT_RST);
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      total_r <= total_nxt;
      ov_r    <= fin;
    end
  end

  always_ff @(posedge clk) begin
    typ_r  <= typ_nxt;
    s_r    <= s_nxt;
    n_r    <= n_nxt;
    e_r    <= e_nxt;
    c_r    <= c_nxt;
    wc_r   <= wc_nxt;
    wp_r   <= wp_nxt;
    wpv_r  <= wpv_nxt;
    nc_r   <= nc_nxt;
    idx_r  <= idx_nxt;
    ilen_r <= ilen_nxt;
    if (fin) begin
      oi_r <= fin_item;
    end
  end
endmodule
`default_nettype wire

/* design/segment_table_block_allocator.sv */
// Allocator of blocks over a segment table held in one single-port-read memory.
// An item is taken when start is high and busy is low, and its result appears on out_item
// for exactly one cycle with out_valid; the receiver cannot stall it, so it must take it
// then. A request rejected in the idle state gives its result in the cycle after it is
// taken. Otherwise an item walks segments from block 0 and tries candidates, followed by
// checks and table writes; each table read waits for its data to return. After reset
// and after every write of total_blocks the table is cleared in one pass over all
// TABLE_DEPTH entries, during which busy is high; cfg_ready is always high.
`default_nettype none
module segment_table_block_allocator
  import stba_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire in_item_t         in_item,
  output logic                  out_valid,
  output out_item_t             out_item,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [TOT_W-1:0] cfg_data
);
  mem_req_t         mreq;
  logic [ENT_W-1:0] rd_data;

  assign cfg_ready = 1'b1;

  stba_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .mreq      (mreq),
    .rd_data   (rd_data)
  );

  stba_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
    .clk     (clk),
    .mreq    (mreq),
    .rd_data (rd_data)
  );
endmodule
`default_nettype wire

/* design/stba_chk.sv */
`default_nettype none
module stba_chk
  import stba_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             start,
  input wire logic             busy,
  input wire in_item_t         in_item,
  input wire logic             out_valid,
  input wire out_item_t        out_item,
  input wire logic             cfg_valid,
  input wire logic             cfg_ready
);
  a_bad_type: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_item.req_type == 2'd3 |=> out_valid && out_item.status == ST_BAD)
    else $error("unknown request type not rejected");

  a_placed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != ST_DONE |-> out_item.placed_block == '0)
    else $error("placed block given on a failed item");

  a_next_only_no_room: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.next_candidate != '0 |-> out_item.status == ST_NO_ROOM)
    else $error("next candidate given without no-room status");

  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> busy)
    else $error("table not cleared after configuration write");
endmodule

bind segment_table_block_allocator stba_chk u_stba_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);
`default_nettype wire

/* sim/tb.sv */
`default_nettype none
module tb;
  import stba_pkg::*;

  localparam int DEPTH = 2048;
  localparam int WATCHDOG_LIMIT = 40000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic out_valid;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [TOT_W-1:0] cfg_data = '0;

  segment_table_block_allocator uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  int seg_len_tbl [DEPTH];
  int managed_blocks;
  out_item_t pending_results[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit timed_out = 1'b0;
  int idle_pct = 0;

  function automatic int mag(int v);
    return v < 0 ? -v : v;
  endfunction

  function automatic int tbl_rd(int i);
    return (i >= 0 && i < DEPTH) ? seg_len_tbl[i] : 0;
  endfunction

  function automatic void tbl_wr(int i, int v);
    if (i >= 0 && i < DEPTH) seg_len_tbl[i] = v;
  endfunction

  function automatic void clear_table(int total);
    foreach (seg_len_tbl[i]) seg_len_tbl[i] = 0;
    managed_blocks = total;
    seg_len_tbl[0] = total;
  endfunction

  function automatic void walk_segments(int blk, output int prv, output int cur);
    int len;
    prv = 0;
    cur = 0;
    while (cur < blk && cur < managed_blocks) begin
      len = mag(tbl_rd(cur));
      if (len == 0) break;
      prv = cur;
      cur += len;
    end
  endfunction

  function automatic bit carve_at(int s, int n, output int nxt);
    int v, prv, cur;
    v = tbl_rd(s);
    nxt = 0;
    if (v != 0) begin
      if (v > 0 && v == n) begin
        tbl_wr(s, -n);
        return 1'b1;
      end
      if (v > n) begin
        tbl_wr(s + n, v - n);
        tbl_wr(s, -n);
        return 1'b1;
      end
      nxt = s + mag(v);
      return 1'b0;
    end
    walk_segments(s, prv, cur);
    v = tbl_rd(prv);
    if (v > 0 && cur >= s && cur - s >= n) begin
      tbl_wr(s, -n);
      tbl_wr(prv, s - prv);
      if (cur > s + n) tbl_wr(s + n, cur - (s + n));
      return 1'b1;
    end
    nxt = cur;
    return 1'b0;
  endfunction

  function automatic logic [1:0] release_segment(int s);
    int prv, cur, v, idx, nx;
    walk_segments(s, prv, cur);
    if (cur != s) return ST_IGNORED;
    v = tbl_rd(s);
    if (v >= 0) return ST_IGNORED;
    tbl_wr(s, -v);
    idx = s;
    if (prv != s && tbl_rd(prv) > 0) begin
      tbl_wr(prv, tbl_rd(prv) + tbl_rd(s));
      tbl_wr(s, 0);
      idx = prv;
    end
    nx = idx + mag(tbl_rd(idx));
    if (nx < managed_blocks && tbl_rd(nx) > 0) begin
      tbl_wr(idx, tbl_rd(idx) + tbl_rd(nx));
      tbl_wr(nx, 0);
    end
    return ST_DONE;
  endfunction

  function automatic out_item_t predict_allocation(in_item_t it);
    out_item_t r;
    int s, n, e, c, nc;
    r = '0;
    r.status = ST_BAD;
    s = it.start_block;
    n = it.block_count;
    e = it.search_end;
    if (it.req_type <= REQ_FREE && s < managed_blocks) begin
      if (it.req_type == REQ_FREE) begin
        r.status = release_segment(s);
      end else if (n != 0) begin
        if (it.req_type == REQ_FIXED) begin
          if (s + n <= managed_blocks) begin
            if (carve_at(s, n, nc)) begin
              r.status = ST_DONE;
              r.placed_block = 11'(s);
            end else begin
              r.status = ST_NO_ROOM;
              r.next_candidate = 12'(nc);
            end
          end
        end else begin
          if (e > managed_blocks) e = managed_blocks;
          r.status = ST_NO_ROOM;
          c = s;
          while (c + n <= e) begin
            if (carve_at(c, n, nc)) begin
              r.status = ST_DONE;
              r.placed_block = 11'(c);
              break;
            end
            if (nc <= c) break;
            c = nc;
          end
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %p", out_item);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_item.status !== exp_r.status || out_item.placed_block !== exp_r.placed_block
            || out_item.next_candidate !== exp_r.next_candidate) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, got %p", exp_r, out_item);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
        timed_out <= 1'b1;
        $display("** segment_table_block_allocator: FAILED **");
        $finish;
      end
    end
  end

  task automatic send_request(in_item_t it, bit has_exp, out_item_t exp_r);
    out_item_t p;
    while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    p = predict_allocation(it);
    if (has_exp && p !== exp_r) begin
      mismatches++;
      if (mismatches <= 10) $display("Table row disagrees: typed %p, predicted %p", exp_r, p);
    end
    pending_results.push_back(p);
  endtask

  task automatic drain_results();
    int guard;
    guard = 0;
    start <= 1'b0;
    while (pending_results.size() != 0 && guard < 5 * WATCHDOG_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
  endtask

  task automatic write_total(int value);
    int t;
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= value[TOT_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    t = value & 12'hFFF;
    if (t == 0) t = 1;
    if (t > DEPTH) t = DEPTH;
    clear_table(t);
  endtask

  function automatic in_item_t make_item(logic [1:0] ty, int s, int n, int e);
    in_item_t it;
    it.req_type = ty;
    it.start_block = s[10:0];
    it.block_count = n[11:0];
    it.search_end = e[11:0];
    return it;
  endfunction

  function automatic out_item_t make_out(logic [1:0] st, int p, int nc);
    out_item_t r;
    r.status = st;
    r.placed_block = p[10:0];
    r.next_candidate = nc[11:0];
    return r;
  endfunction

  typedef struct {
    in_item_t req;
    bit has_exp;
    out_item_t exp_r;
  } stim_row_t;

  task automatic random_phase(int count, int total);
    in_item_t it;
    int k, n;
    for (k = 0; k < count; k++) begin
      n = ($urandom_range(9, 0) == 0) ? $urandom_range(4095, 0) : $urandom_range(16, 1);
      case ($urandom_range(9, 0))
        0, 1, 2: it = make_item(REQ_FIXED, $urandom_range(total - 1, 0), n, 0);
        3, 4, 5: it = make_item(REQ_SEARCH, $urandom_range(total - 1, 0), n,
                                $urandom_range(4095, 0));
        6, 7, 8: it = make_item(REQ_FREE, $urandom_range(total - 1, 0), 0, 0);
        default: begin
          it = in_item_t'($urandom());
          it.start_block = 11'($urandom_range(2047, 0));
        end
      endcase
      if ($urandom_range(3, 0) == 0) it.search_end = 12'($urandom_range(4095, 0));
      send_request(it, 1'b0, '0);
    end
  endtask

  stim_row_t stim_rows[$];

  initial begin
    clear_table(DEPTH);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    stim_rows.push_back('{make_item(2'd3, 0, 1, 1), 1, make_out(ST_BAD, 0, 0)});
    stim_rows.push_back('{make_item(REQ_FIXED, 0, 0, 0), 1, make_out(ST_BAD, 0, 0)});
    stim_rows.push_back('{make_item(REQ_FREE, 0, 0, 0), 1, make_out(ST_IGNORED, 0, 0)});
    stim_rows.push_back('{make_item(REQ_FIXED, 2047, 2, 0), 1, make_out(ST_BAD, 0, 0)});
    stim_rows.push_back('{make_item(REQ_FIXED, 0, 1, 0), 1, make_out(ST_DONE, 0, 0)});
    stim_rows.push_back('{make_item(REQ_FIXED, 0, 4, 0), 1, make_out(ST_NO_ROOM, 0, 1)});
    stim_rows.push_back('{make_item(REQ_FIXED, 100, 10, 0), 0, '0});
    stim_rows.push_back('{make_item(REQ_FIXED, 110, 90, 0), 0, '0});
    stim_rows.push_back('{make_item(REQ_FIXED, 105, 3, 0), 0, '0});
    stim_rows.push_back('{make_item(REQ_SEARCH, 0, 50, 4095), 0, '0});
    stim_rows.push_back('{make_item(REQ_SEARCH, 0, 2000, 4095), 0, '0});
    stim_rows.push_back('{make_item(REQ_SEARCH, 50, 5, 40), 0, '0});
    stim_rows.push_back('{make_item(REQ_FREE, 105, 0, 0), 0, '0});
    stim_rows.push_back('{make_item(REQ_FREE, 100, 0, 0), 0, '0});
    stim_rows.push_back('{make_item(REQ_FREE, 110, 0, 0), 0, '0});
    stim_rows.push_back('{make_item(REQ_FREE, 0, 0, 0), 0, '0});
    stim_rows.push_back('{make_item(REQ_FIXED, 2047, 1, 4095), 0, '0});
    stim_rows.push_back('{make_item(REQ_SEARCH, 1, 4095, 4095), 0, '0});
    stim_rows.push_back('{make_item(REQ_FREE, 2047, 4095, 4095), 0, '0});
    foreach (stim_rows[i]) send_request(stim_rows[i].req, stim_rows[i].has_exp,
                                        stim_rows[i].exp_r);

    random_phase(60, DEPTH);
    drain_results();
    idle_pct = 55;
    write_total(0);
    random_phase(20, 1);
    write_total(4095);
    random_phase(50, DEPTH);
    idle_pct = 20;
    write_total(64);
    random_phase(80, 64);
    idle_pct = 0;
    write_total(2048);
    random_phase(40, 2048);
    write_total(300);
    random_phase(40, 300);

    drain_results();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("** segment_table_block_allocator: PASSED **");
    end else begin
      $display("** segment_table_block_allocator: FAILED **");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* files.f */
design/stba_pkg.sv
design/stba_table.sv
design/stba_ctrl.sv
design/segment_table_block_allocator.sv
design/stba_chk.sv
sim/tb.sv
